// ===== hw/rtl/kma_pkg.sv =====
package kma_pkg;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_NEW     = 3'd1,
    ST_FULL    = 3'd2,
    ST_SAT     = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  localparam logic signed [14:0] LEVEL_MAX_RESET = -15'sd16000;
  localparam logic [15:0]        COUNT_LIMIT     = 16'hFFFF;
  localparam int                 KEY_W           = 40;
  localparam int                 SUM_W           = 28;
  localparam int                 CNT_W           = 16;
  localparam int                 ENTRY_W         = KEY_W + SUM_W + CNT_W;

endpackage

// ===== hw/rtl/kma_ram.sv =====
module kma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/kma_div.sv =====
// Restoring divider for the rounded average: q = (mag + cnt/2) / cnt,
// one quotient bit per cycle.
module kma_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [27:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [27:0] quotient
);

  logic [27:0] rem;
  logic [4:0]  bits;
  logic        busy;
  logic [16:0] trial;

  assign trial = {rem[15:0], quotient[27]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        bits     <= 5'd28;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        if (!trial[16]) begin
          rem      <= {12'd0, trial[15:0]};
          quotient <= {quotient[26:0], 1'b1};
        end else begin
          rem      <= {rem[26:0], quotient[27]};
          quotient <= {quotient[26:0], 1'b0};
        end
        bits <= bits - 5'd1;
        if (bits == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/keyed_measurement_averager.sv =====
// Keyed measurement averager.
// Input channel (in_valid/in_stall) carries op, pos_x, pos_y, ap_id, level.
// Output channel (out_valid/out_stall) returns one result item per input item:
// status, the matched entry's rounded average and count, and the running
// statistics (total samples, unique places, unique aps, weakest, strongest).
// Entries live in one RAM of ENTRIES words {key, sum, count}, filled in order,
// so the fill count serves as the valid mark and a clear only resets it.
// Access-point seen bits are a flop vector cleared at once.
// The lookup reads and compares one filled entry at a time in two states
// (S_READ presents the address, S_CMP compares the registered data). A new
// entry or a table-full drop is ready once the lookup ends; a match first
// runs the 28-step bit-serial divider (S_DIV, S_WAITD, S_DONE).
// A clear goes straight to the output register.
// One item is in work at a time; in_stall is high while busy or while the
// result waits in the output register. The next item can be taken in the
// cycle after the result is accepted.
// Reset (synchronous, rst high) empties the table and statistics, no sweep.
// A stalled result holds on the outputs until out_stall drops.
module keyed_measurement_averager #(
  parameter int ENTRIES = 256,
  parameter int AP_IDS  = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic [7:0]         ap_id,
  input  logic signed [11:0] level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [11:0] entry_average,
  output logic [15:0]        entry_count,
  output logic [31:0]        total_samples,
  output logic [8:0]         place_count,
  output logic [8:0]         unique_aps,
  output logic signed [11:0] weakest,
  output logic signed [14:0] strongest
);

  localparam int AW  = $clog2(ENTRIES);
  localparam int FW  = $clog2(ENTRIES + 1);
  localparam int PW  = $clog2(AP_IDS);
  localparam int APW = $clog2(AP_IDS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_WAITD = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  // captured item
  logic [kma_pkg::KEY_W-1:0] key;
  logic signed [11:0]        lv;
  logic [PW-1:0]             ap_idx;

  // table and stats
  logic [FW-1:0]      places;
  logic [APW-1:0]     aps;
  logic [AP_IDS-1:0]  ap_seen;
  logic [31:0]        total;
  logic signed [11:0] lmin;
  logic signed [14:0] lmax;

  logic [AW-1:0]      scan;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [kma_pkg::ENTRY_W-1:0] wdata, rdata;

  logic signed [27:0] sum_new;
  logic [15:0]        cnt_new;
  logic               neg;
  logic               div_start, div_done;
  logic [27:0]        div_q, mag;

  kma_ram #(.WIDTH(kma_pkg::ENTRY_W), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(scan), .rdata(rdata)
  );

  kma_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(mag + {13'd0, cnt_new[15:1]}), .divisor(cnt_new),
    .done(div_done), .quotient(div_q)
  );

  logic [kma_pkg::KEY_W-1:0] r_key;
  logic signed [27:0]        r_sum;
  logic [15:0]               r_cnt;
  assign r_key = rdata[kma_pkg::ENTRY_W-1 -: kma_pkg::KEY_W];
  assign r_sum = rdata[kma_pkg::CNT_W +: kma_pkg::SUM_W];
  assign r_cnt = rdata[kma_pkg::CNT_W-1:0];

  assign mag = neg ? 28'(-sum_new) : sum_new;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign place_count   = 9'(places);
  assign unique_aps    = 9'(aps);
  assign total_samples = total;
  assign weakest   = lmin;
  assign strongest = lmax;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      places  <= '0;
      aps     <= '0;
      ap_seen <= '0;
      total   <= '0;
      lmin    <= '0;
      lmax    <= kma_pkg::LEVEL_MAX_RESET;
      we      <= 1'b0;
      div_start <= 1'b0;
    end else begin
      we        <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            key    <= {pos_x, pos_y, ap_id};
            lv     <= level;
            ap_idx <= PW'(32'(ap_id) % AP_IDS);
            scan   <= '0;
            if (op) begin
              places  <= '0;
              aps     <= '0;
              ap_seen <= '0;
              total   <= '0;
              lmin    <= '0;
              lmax    <= kma_pkg::LEVEL_MAX_RESET;
              status  <= kma_pkg::ST_CLEARED;
              entry_average <= '0;
              entry_count   <= '0;
              state <= S_OUT;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // RAM address presented; data next cycle
          state <= S_CMP;
        end
        S_CMP: begin
          if (FW'(scan) < places && r_key == key) begin
            if (r_cnt == kma_pkg::COUNT_LIMIT) begin
              status  <= kma_pkg::ST_SAT;
              sum_new <= r_sum;
              cnt_new <= r_cnt;
              neg     <= r_sum[27];
            end else begin
              status  <= kma_pkg::ST_ADDED;
              sum_new <= r_sum + 28'(lv);
              cnt_new <= r_cnt + 16'd1;
              neg     <= (r_sum + 28'(lv)) < 0;
              we      <= 1'b1;
              waddr   <= scan;
              wdata   <= {key, r_sum + 28'(lv), r_cnt + 16'd1};
              if (total != 32'hFFFF_FFFF) total <= total + 32'd1;
              if (lv < lmin) lmin <= lv;
              if (15'(lv) > lmax) lmax <= 15'(lv);
            end
            state <= S_DIV;
          end else if (FW'(scan) + FW'(1) < places && scan != AW'(ENTRIES - 1)) begin
            scan  <= scan + AW'(1);
            state <= S_READ;
          end else if (places == FW'(ENTRIES)) begin
            status <= kma_pkg::ST_FULL;
            entry_average <= '0;
            entry_count   <= '0;
            state <= S_OUT;
          end else begin
            we    <= 1'b1;
            waddr <= AW'(places);
            wdata <= {key, 28'(lv), 16'd1};
            places <= places + FW'(1);
            if (!ap_seen[ap_idx]) begin
              ap_seen[ap_idx] <= 1'b1;
              aps <= aps + APW'(1);
            end
            if (total != 32'hFFFF_FFFF) total <= total + 32'd1;
            if (lv < lmin) lmin <= lv;
            if (15'(lv) > lmax) lmax <= 15'(lv);
            status <= kma_pkg::ST_NEW;
            entry_average <= lv;
            entry_count   <= 16'd1;
            state <= S_OUT;
          end
        end
        S_DIV: begin
          div_start <= 1'b1;
          state <= S_WAITD;
        end
        S_WAITD: begin
          if (div_done) state <= S_DONE;
        end
        S_DONE: begin
          entry_average <= neg ? 12'(-div_q) : 12'(div_q);
          entry_count   <= cnt_new;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
